// ----- hw/rtl/xbm_pkg.sv -----
// Shared types, constants and helper functions for the centred XBM blit unit.
// No dependencies; imported by every module of the block.

package xbm_pkg;

    // Default screen geometry and framebuffer row pitch
    localparam int XBM_SCREEN_WIDTH  = 178;
    localparam int XBM_SCREEN_HEIGHT = 128;
    localparam int XBM_ROW_STRIDE    = 60;

    // Register reset values
    localparam logic [7:0] XBM_WIDTH_RESET  = 8'd178;
    localparam logic [7:0] XBM_HEIGHT_RESET = 8'd128;

    // Register indexes (paddr bit 2)
    localparam logic XBM_REG_WIDTH  = 1'b0;
    localparam logic XBM_REG_HEIGHT = 1'b1;

    // Depth of the queue between front and back (power of two)
    localparam int XBM_QUEUE_DEPTH = 2;

    // Bit pair set for one lit pixel
    localparam logic [7:0] XBM_PAIR = 8'b00000011;

    // Reciprocal of three, exact for values below 2048
    localparam logic [19:0] XBM_RECIP3 = 20'd683;
    localparam int          XBM_RECIP3_SHIFT = 11;

    // Configuration as used by the datapath, derived from the two registers
    typedef struct packed {
        logic [7:0]  width;       // clamped width
        logic [7:0]  height;      // clamped height
        logic [5:0]  stride;      // source bytes per row
        logic [8:0]  startx_div;  // startx / 3
        logic [1:0]  startx_mod;  // startx % 3
        logic [12:0] row_base0;   // starty * row stride
    } xbm_cfg_t;

    // One classified source byte, passed from front to back
    typedef struct packed {
        logic [11:0] slots;     // valid pixels placed at their pixel slot
        logic [1:0]  last_idx;  // index of the final framebuffer byte touched
        logic [12:0] addr0;     // address of the first framebuffer byte
        logic        done;      // last byte of the image
    } xbm_entry_t;

    // Clamp the registers and work out the centring offsets
    function automatic xbm_cfg_t xbm_derive(input logic [7:0] w_raw,
                                            input logic [7:0] h_raw,
                                            input int sw, input int sh, input int rs);
        logic [10:0] w;
        logic [10:0] h;
        logic [10:0] dx_span;
        logic [10:0] dy_span;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [19:0] prod;
        logic [8:0]  q;
        logic [9:0]  r3;
        logic [22:0] rb;
        xbm_cfg_t    c;
        w = (w_raw == 8'd0) ? 11'd1 : {3'b000, w_raw};
        if (w > 11'(sw))
        begin
            w = 11'(sw);
        end
        h = (h_raw == 8'd0) ? 11'd1 : {3'b000, h_raw};
        if (h > 11'(sh))
        begin
            h = 11'(sh);
        end
        dx_span = 11'(sw) - w;
        sx      = dx_span[10:1];
        prod    = 20'(sx) * XBM_RECIP3;
        q       = prod[XBM_RECIP3_SHIFT +: 9];
        r3      = sx - ({1'b0, q} + {q, 1'b0});
        dy_span = 11'(sh) - h;
        sy      = dy_span[10:1];
        rb      = 23'(sy) * 23'(rs);
        c.width      = w[7:0];
        c.height     = h[7:0];
        c.stride     = 6'((w + 11'd7) >> 3);
        c.startx_div = q;
        c.startx_mod = r3[1:0];
        c.row_base0  = rb[12:0];
        return c;
    endfunction

    // Index of the last framebuffer byte for a span of pixel slots (0..9)
    function automatic logic [1:0] xbm_last_idx(input logic [3:0] span);
        logic [1:0] idx;
        case (span) inside
            [4'd0:4'd2]: idx = 2'd0;
            [4'd3:4'd5]: idx = 2'd1;
            [4'd6:4'd8]: idx = 2'd2;
            default:     idx = 2'd3;
        endcase
        return idx;
    endfunction

endpackage

// ----- hw/rtl/xbm_queue.sv -----
// Short queue of classified source bytes between the front and the back.
// Depends on xbm_pkg for the entry type and depth.

module xbm_queue
    import xbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  xbm_entry_t wdata,
    output logic       full,
    input  logic       rd,
    output xbm_entry_t rdata,
    output logic       rvalid
);

    localparam int PW = (XBM_QUEUE_DEPTH > 1) ? $clog2(XBM_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(XBM_QUEUE_DEPTH + 1);

    xbm_entry_t          store_reg [XBM_QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                do_wr, do_rd;

    assign full   = (count_reg == CW'(XBM_QUEUE_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = store_reg[rd_ptr_reg];
    assign do_wr  = wr && !full;
    assign do_rd  = rd && rvalid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(XBM_QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A lone write raises the count by one
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("queue count not raised on write");

endmodule

// ----- hw/rtl/xbm_front.sv -----
// Front part: accepts source bytes, tracks the image position and classifies
// each byte into a queue entry. Depends on xbm_pkg.

module xbm_front
    import xbm_pkg::*;
#(
    parameter int SCREEN_WIDTH  = XBM_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = XBM_SCREEN_HEIGHT,
    parameter int ROW_STRIDE    = XBM_ROW_STRIDE
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] src_byte,
    input  xbm_cfg_t   cfg,
    input  logic       restart,
    input  xbm_cfg_t   cfg_load,
    input  logic       q_full,
    output logic       q_wr,
    output xbm_entry_t q_data
);

    localparam xbm_cfg_t CFG_RESET = xbm_derive(XBM_WIDTH_RESET, XBM_HEIGHT_RESET,
                                                SCREEN_WIDTH, SCREEN_HEIGHT, ROW_STRIDE);

    logic [6:0]  row_reg, row_next;
    logic [4:0]  col_reg, col_next;
    logic [7:0]  rem_reg, rem_next;        // pixels left in the row
    logic [8:0]  fb_reg, fb_next;          // framebuffer byte of first pixel
    logic [1:0]  pos_reg, pos_next;        // pixel slot of first pixel
    logic [12:0] rowbase_reg, rowbase_next;

    logic [3:0]  n_pix;
    logic [7:0]  masked;
    logic [3:0]  span;
    logic        col_last, row_last, row_wrap;
    logic [2:0]  pos_adv;

    assign q_wr = push && !q_full;

    // Classify the current byte
    always_comb
    begin
        n_pix = (rem_reg > 8'd8) ? 4'd8 : rem_reg[3:0];
        for (int i = 0; i < 8; i++)
        begin
            masked[i] = src_byte[i] && (4'(i) < n_pix);
        end
        span     = 4'({2'b00, pos_reg} + n_pix - 4'd1);
        col_last = (({1'b0, col_reg} + 6'd1) == cfg.stride);
        row_last = (({1'b0, row_reg} + 8'd1) == cfg.height);
        row_wrap = row_last || (row_reg == 7'h7F);

        q_data.slots    = 12'(masked) << pos_reg;
        q_data.last_idx = xbm_last_idx(span);
        q_data.addr0    = rowbase_reg + 13'(fb_reg);
        q_data.done     = row_last && col_last;
    end

    // Position counters
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        rem_next     = rem_reg;
        fb_next      = fb_reg;
        pos_next     = pos_reg;
        rowbase_next = rowbase_reg;
        pos_adv      = {1'b0, pos_reg} + 3'd2;
        if (restart)
        begin
            row_next     = '0;
            col_next     = '0;
            rem_next     = cfg_load.width;
            fb_next      = cfg_load.startx_div;
            pos_next     = cfg_load.startx_mod;
            rowbase_next = cfg_load.row_base0;
        end
        else if (q_wr)
        begin
            if (col_last)
            begin
                col_next = '0;
                rem_next = cfg.width;
                fb_next  = cfg.startx_div;
                pos_next = cfg.startx_mod;
                if (row_wrap)
                begin
                    row_next     = '0;
                    rowbase_next = cfg.row_base0;
                end
                else
                begin
                    row_next     = 7'(row_reg + 1'b1);
                    rowbase_next = rowbase_reg + 13'(ROW_STRIDE);
                end
            end
            else
            begin
                col_next = 5'(col_reg + 1'b1);
                rem_next = rem_reg - 8'd8;
                // eight pixels = two whole bytes plus two slots
                if (pos_adv >= 3'd3)
                begin
                    pos_next = 2'(pos_adv - 3'd3);
                    fb_next  = fb_reg + 9'd3;
                end
                else
                begin
                    pos_next = pos_adv[1:0];
                    fb_next  = fb_reg + 9'd2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            rem_reg     <= CFG_RESET.width;
            fb_reg      <= CFG_RESET.startx_div;
            pos_reg     <= CFG_RESET.startx_mod;
            rowbase_reg <= CFG_RESET.row_base0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            rem_reg     <= rem_next;
            fb_reg      <= fb_next;
            pos_reg     <= pos_next;
            rowbase_reg <= rowbase_next;
        end
    end

    // The image's last byte brings both counters back to the start
    a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && q_data.done) |=> ((row_reg == '0) && (col_reg == '0)))
        else $error("counters did not wrap after last byte");

endmodule

// ----- hw/rtl/xbm_back.sv -----
// Back part: each queued byte gives one to four framebuffer requests, one
// per cycle while popped or idle, held in an output register. Uses xbm_pkg.

module xbm_back
    import xbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  xbm_entry_t  head,
    input  logic        head_valid,
    output logic        head_take,
    input  logic        pop,
    output logic        empty,
    output logic [12:0] fb_address,
    output logic [7:0]  or_mask,
    output logic        last,
    output logic        image_done
);

    logic [1:0]  j_reg, j_next;
    logic        out_valid_reg, out_valid_next;
    logic [12:0] addr_reg;
    logic [7:0]  mask_reg;
    logic        last_reg, done_reg;

    logic        load;
    logic [2:0]  trip;
    logic [7:0]  mask_cur;
    logic        is_last;

    assign empty      = !out_valid_reg;
    assign fb_address = addr_reg;
    assign or_mask    = mask_reg;
    assign last       = last_reg;
    assign image_done = done_reg;

    // Pick the three pixel slots of the current framebuffer byte
    always_comb
    begin
        case (j_reg)
            2'd0:    trip = head.slots[2:0];
            2'd1:    trip = head.slots[5:3];
            2'd2:    trip = head.slots[8:6];
            default: trip = head.slots[11:9];
        endcase
        mask_cur = (trip[0] ? (XBM_PAIR << 6) : 8'h00)
                 | (trip[1] ? (XBM_PAIR << 3) : 8'h00)
                 | (trip[2] ? XBM_PAIR : 8'h00);
        is_last   = (j_reg == head.last_idx);
        load      = head_valid && (!out_valid_reg || pop);
        head_take = load && is_last;
    end

    // Sequencer and output valid
    always_comb
    begin
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            j_next         = is_last ? 2'd0 : 2'(j_reg + 1'b1);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= head.addr0 + 13'(j_reg);
            mask_reg <= mask_cur;
            last_reg <= is_last;
            done_reg <= head.done;
        end
    end

    // The step counter never runs past the entry's last byte
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (j_reg <= head.last_idx))
        else $error("step counter beyond last byte");

    // The counter is back at zero whenever the queue has nothing
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (j_reg == 2'd0))
        else $error("step counter not at zero while queue empty");

endmodule

// ----- hw/rtl/xbm_centered_blit_three_per_byte_unit.sv -----
// Centred XBM blit, three pixels per framebuffer byte: config registers and top.
// Throughput: one to four requests per source byte, one request per cycle
// while the output is popped or empty, set by the back sequencer that steps
// through the framebuffer bytes touched.
// Reset: width 178, height 128, row and column zero, queue and output empty.
// Depends on xbm_pkg, xbm_front, xbm_queue and xbm_back.

module xbm_centered_blit_three_per_byte_unit
    import xbm_pkg::*;
#(
    parameter int SCREEN_WIDTH  = XBM_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = XBM_SCREEN_HEIGHT,
    parameter int ROW_STRIDE    = XBM_ROW_STRIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // source bytes
    input  logic        push,
    output logic        full,
    input  logic [7:0]  src_byte,
    // framebuffer requests
    output logic        empty,
    input  logic        pop,
    output logic [12:0] fb_address,
    output logic [7:0]  or_mask,
    output logic        last,
    output logic        image_done
);

    localparam xbm_cfg_t CFG_RESET = xbm_derive(XBM_WIDTH_RESET, XBM_HEIGHT_RESET,
                                                SCREEN_WIDTH, SCREEN_HEIGHT, ROW_STRIDE);

    logic [7:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    xbm_cfg_t   cfg_reg, cfg_next;
    logic       cfg_wr;

    xbm_entry_t q_wdata, q_rdata;
    logic       q_wr, q_full, q_rd, q_rvalid;

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                XBM_REG_WIDTH:  width_next  = pwdata[7:0];
                XBM_REG_HEIGHT: height_next = pwdata[7:0];
                default:        width_next  = width_reg;
            endcase
        end
        cfg_next = xbm_derive(width_next, height_next,
                              SCREEN_WIDTH, SCREEN_HEIGHT, ROW_STRIDE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= XBM_WIDTH_RESET;
            height_reg <= XBM_HEIGHT_RESET;
            cfg_reg    <= CFG_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            cfg_reg    <= cfg_next;
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[2])
            XBM_REG_HEIGHT: prdata = {24'h000000, height_reg};
            default:        prdata = {24'h000000, width_reg};
        endcase
    end

    assign full = q_full;

    xbm_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ROW_STRIDE    (ROW_STRIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .src_byte (src_byte),
        .cfg      (cfg_reg),
        .restart  (cfg_wr),
        .cfg_load (cfg_next),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (q_wdata)
    );

    xbm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wdata  (q_wdata),
        .full   (q_full),
        .rd     (q_rd),
        .rdata  (q_rdata),
        .rvalid (q_rvalid)
    );

    xbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_rdata),
        .head_valid (q_rvalid),
        .head_take  (q_rd),
        .pop        (pop),
        .empty      (empty),
        .fb_address (fb_address),
        .or_mask    (or_mask),
        .last       (last),
        .image_done (image_done)
    );

endmodule
